### src/vfa_pkg.sv
// Shared constants, command codes, pipeline payload types and the clamp helper of the vector ALU.
`timescale 1ns / 1ps
package vfa_pkg;

  // Fraction bits of the signed fixed-point words.
  localparam int FRAC_BITS = 16;
  // Quotient bits of one divide: integer part plus fraction.
  localparam int DW = 32 + FRAC_BITS;
  // Result bits of the square root, one per stage.
  localparam int SQ_STAGES = 32;

  localparam logic signed [65:0] W_MAX66 = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] W_MIN66 = ~W_MAX66;
  localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    CMD_ADDV  = 4'd0,
    CMD_ADDS  = 4'd1,
    CMD_SUBV  = 4'd2,
    CMD_SUBS  = 4'd3,
    CMD_MULV  = 4'd4,
    CMD_MULS  = 4'd5,
    CMD_DIVV  = 4'd6,
    CMD_DIVS  = 4'd7,
    CMD_NEG   = 4'd8,
    CMD_DOT   = 4'd9,
    CMD_CROSS = 4'd10,
    CMD_LENSQ = 4'd11,
    CMD_LEN   = 4'd12,
    CMD_NORM  = 4'd13,
    CMD_MAX   = 4'd14,
    CMD_MIN   = 4'd15
  } cmd_t;

  typedef logic [31:0] word_t;

  // Payload carried alongside the square root. For divides and normalise the vector slot
  // holds operand A, otherwise the finished result vector.
  typedef struct packed {
    cmd_t            cmd;
    word_t [2:0]     vec;
    word_t [2:0]     den;
    word_t           sc;
    logic            sat;
  } pre_t;

  // Payload carried alongside the dividers.
  typedef struct packed {
    cmd_t            cmd;
    word_t [2:0]     vec;
    word_t           sc;
    logic            sat;
    logic [2:0]      qneg;
    logic [2:0]      dzl;
    logic [2:0]      aneg;
    logic            zl;
  } post_t;

  // Clamps a wide signed value to 32 bits; the top bit of the result is the clamp flag.
  function automatic logic [32:0] sat_word(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > W_MAX66) begin
      r = {1'b1, W_MAX};
    end else if (v < W_MIN66) begin
      r = {1'b1, W_MIN};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

### src/vec3_fixed_point_alu_unit.sv
// Pipelined three-component fixed-point vector ALU: arithmetic, products, square root, divides.
//
//   Channel | Ports                      | Contents (lowest bit first)
//   --------+----------------------------+-------------------------------------------------
//   input   | in_tvalid/tready/tdata/tuser  | tdata: a_x a_y a_z b_x b_y b_z scalar_operand
//           |                            | tuser: command
//   output  | out_tvalid/tready/tdata/tuser | tdata: res_x res_y res_z res_scalar
//           |                            | tuser: saturated divide_by_zero zero_length
//
// One beat is accepted every cycle unless the output stalls. Every command takes the same
// path: four stages of operand, multiply, sum and clamp, the 32-stage square root, divider
// set-up, the restoring dividers that resolve one quotient bit per stage, and the output
// register. The whole pipeline advances together whenever the output register is empty or
// its beat is being taken, so a stall freezes every stage and nothing is lost or repeated.
// The synchronous active-low reset clears only the valid bits.
`timescale 1ns / 1ps
module vec3_fixed_point_alu_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [223:0] in_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, scalar_operand
  input  logic [3:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // res_x, res_y, res_z, res_scalar
  output logic [2:0]   out_tuser   // saturated, divide_by_zero, zero_length
);
  import vfa_pkg::*;

  // Global advance: every stage moves when the output register can take a new beat.
  logic adv;

  // Stage 0: registered operands.
  logic               v0_r;
  cmd_t               cmd0_r;
  logic signed [31:0] a0_r [3];
  logic signed [31:0] b0_r [3];
  logic signed [31:0] s0_r;

  // Stage 1: products and simple results.
  logic               v1_r;
  cmd_t               cmd1_r;
  logic signed [63:0] p1_r [6];
  logic signed [63:0] p_nxt [6];
  logic signed [32:0] simp1_r [3];
  logic signed [32:0] simp_nxt [3];
  logic signed [31:0] a1_r [3];
  logic signed [31:0] den1_r [3];
  logic signed [31:0] den_nxt [3];

  // Stage 2: exact sums.
  logic               v2_r;
  cmd_t               cmd2_r;
  logic signed [65:0] lane2_r [3];
  logic signed [65:0] lane_nxt [3];
  logic signed [65:0] sum2_r;
  logic signed [31:0] a2_r [3];
  logic signed [31:0] den2_r [3];

  // Square root stages; index 0 is the clamp stage output.
  logic        sqv_r [SQ_STAGES+1];
  logic [63:0] sqn_r [SQ_STAGES+1];
  logic [63:0] sqq_r [SQ_STAGES+1];
  pre_t        pre_r [SQ_STAGES+1];
  logic [63:0] sqn_nxt [SQ_STAGES+1];
  logic [63:0] sqq_nxt [SQ_STAGES+1];
  pre_t        pre_nxt;

  // Divider stages; index 0 is the set-up stage output.
  logic          dv_r   [DW+1];
  post_t         post_r [DW+1];
  logic [32:0]   rem_r  [DW+1][3];
  logic [DW-1:0] qd_r   [DW+1][3];
  logic [31:0]   dsr_r  [DW+1][3];
  post_t         post_nxt;
  logic [DW-1:0] qd0_nxt  [3];
  logic [31:0]   dsr0_nxt [3];
  logic [32:0]   rem_nxt [DW+1][3];
  logic [DW-1:0] qd_nxt  [DW+1][3];
  logic [31:0]   dsr_nxt [DW+1][3];

  // Output register.
  logic         out_valid_r;
  logic [127:0] out_data_r;
  logic [2:0]   out_user_r;
  logic [127:0] out_data_nxt;
  logic [2:0]   out_user_nxt;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ---------------------------------------------------------------- valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= SQ_STAGES; k++) begin
        sqv_r[k] <= 1'b0;
      end
      for (int j = 0; j <= DW; j++) begin
        dv_r[j] <= 1'b0;
      end
    end else if (adv) begin
      v0_r     <= in_tvalid;
      v1_r     <= v0_r;
      v2_r     <= v1_r;
      sqv_r[0] <= v2_r;
      for (int k = 1; k <= SQ_STAGES; k++) begin
        sqv_r[k] <= sqv_r[k-1];
      end
      dv_r[0] <= sqv_r[SQ_STAGES];
      for (int j = 1; j <= DW; j++) begin
        dv_r[j] <= dv_r[j-1];
      end
      out_valid_r <= dv_r[DW];
    end
  end

  // ---------------------------------------------------------------- stage 0
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd0_r <= cmd_t'(in_tuser);
      for (int i = 0; i < 3; i++) begin
        a0_r[i] <= in_tdata[32*i +: 32];
        b0_r[i] <= in_tdata[96 + 32*i +: 32];
      end
      s0_r <= in_tdata[192 +: 32];
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Lanes 0..2 form the direct products, lanes 3..5 the subtracted cross terms.
  always_comb begin
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] opnd;
    int j;
    int k;
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      k = (i == 0) ? 2 : i - 1;
      mx = (cmd0_r == CMD_CROSS) ? a0_r[j] : a0_r[i];
      case (cmd0_r)
        CMD_CROSS:                    my = b0_r[k];
        CMD_MULS:                     my = s0_r;
        CMD_LENSQ, CMD_LEN, CMD_NORM: my = a0_r[i];
        default:                      my = b0_r[i];
      endcase
      p_nxt[i]   = mx * my;
      p_nxt[3+i] = a0_r[k] * b0_r[j];

      opnd = (cmd0_r inside {CMD_ADDS, CMD_SUBS}) ? s0_r : b0_r[i];
      case (cmd0_r)
        CMD_ADDV, CMD_ADDS: simp_nxt[i] = 33'(a0_r[i]) + 33'(opnd);
        CMD_SUBV, CMD_SUBS: simp_nxt[i] = 33'(a0_r[i]) - 33'(opnd);
        CMD_NEG:            simp_nxt[i] = -33'(a0_r[i]);
        CMD_MAX:            simp_nxt[i] = 33'((a0_r[i] > b0_r[i]) ? a0_r[i] : b0_r[i]);
        CMD_MIN:            simp_nxt[i] = 33'((a0_r[i] < b0_r[i]) ? a0_r[i] : b0_r[i]);
        default:            simp_nxt[i] = '0;
      endcase
      den_nxt[i] = (cmd0_r == CMD_DIVS) ? s0_r : b0_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r <= cmd0_r;
      for (int i = 0; i < 6; i++) begin
        p1_r[i] <= p_nxt[i];
      end
      for (int i = 0; i < 3; i++) begin
        simp1_r[i] <= simp_nxt[i];
        a1_r[i]    <= a0_r[i];
        den1_r[i]  <= den_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (cmd1_r)
        CMD_MULV, CMD_MULS: lane_nxt[i] = 66'(p1_r[i]);
        CMD_CROSS:          lane_nxt[i] = 66'(p1_r[i]) - 66'(p1_r[3+i]);
        default:            lane_nxt[i] = 66'(simp1_r[i]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd2_r <= cmd1_r;
      sum2_r <= 66'(p1_r[0]) + 66'(p1_r[1]) + 66'(p1_r[2]);
      for (int i = 0; i < 3; i++) begin
        lane2_r[i] <= lane_nxt[i];
        a2_r[i]    <= a1_r[i];
        den2_r[i]  <= den1_r[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: floor and clamp
  always_comb begin
    logic [32:0] sw;
    sw          = '0;
    pre_nxt     = '0;
    pre_nxt.cmd = cmd2_r;
    for (int i = 0; i < 3; i++) begin
      pre_nxt.den[i] = den2_r[i];
      case (cmd2_r)
        CMD_MULV, CMD_MULS, CMD_CROSS: begin
          sw = sat_word(lane2_r[i] >>> FRAC_BITS);
          pre_nxt.vec[i] = sw[31:0];
          pre_nxt.sat    = pre_nxt.sat | sw[32];
        end
        CMD_DIVV, CMD_DIVS, CMD_NORM: begin
          pre_nxt.vec[i] = a2_r[i];
        end
        CMD_DOT, CMD_LENSQ, CMD_LEN: begin
          pre_nxt.vec[i] = '0;
        end
        default: begin
          sw = sat_word(lane2_r[i]);
          pre_nxt.vec[i] = sw[31:0];
          pre_nxt.sat    = pre_nxt.sat | sw[32];
        end
      endcase
    end
    if (cmd2_r inside {CMD_DOT, CMD_LENSQ}) begin
      sw = sat_word(sum2_r >>> FRAC_BITS);
      pre_nxt.sc  = sw[31:0];
      pre_nxt.sat = pre_nxt.sat | sw[32];
    end
  end

  // ---------------------------------------------------------------- square root
  // Digit recurrence, one root bit per stage. Leading stages whose test bit exceeds the
  // radicand simply fail their compare, which matches skipping them.
  always_comb begin
    logic [63:0] bitv;
    logic [63:0] t;
    sqn_nxt[0] = sum2_r[63:0];
    sqq_nxt[0] = '0;
    for (int k = 0; k < SQ_STAGES; k++) begin
      bitv = 64'd1 << (62 - 2*k);
      t    = sqq_r[k] + bitv;
      if (sqn_r[k] >= t) begin
        sqn_nxt[k+1] = sqn_r[k] - t;
        sqq_nxt[k+1] = (sqq_r[k] >> 1) + bitv;
      end else begin
        sqn_nxt[k+1] = sqn_r[k];
        sqq_nxt[k+1] = sqq_r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_r[0] <= pre_nxt;
      for (int k = 0; k <= SQ_STAGES; k++) begin
        sqn_r[k] <= sqn_nxt[k];
        sqq_r[k] <= sqq_nxt[k];
      end
      for (int k = 1; k <= SQ_STAGES; k++) begin
        pre_r[k] <= pre_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- divider set-up
  // Divides work on magnitudes; the sign is put back at the end.
  always_comb begin
    pre_t        pc;
    logic [31:0] len;
    logic [31:0] amag;
    logic [31:0] dmag;
    pc  = pre_r[SQ_STAGES];
    len = sqq_r[SQ_STAGES][31:0];
    post_nxt     = '0;
    post_nxt.cmd = pc.cmd;
    post_nxt.vec = pc.vec;
    post_nxt.sc  = pc.sc;
    post_nxt.sat = pc.sat;
    post_nxt.zl  = (pc.cmd == CMD_NORM) && (len == '0);
    if (pc.cmd == CMD_LEN) begin
      post_nxt.sc  = len[31] ? W_MAX : len;
      post_nxt.sat = len[31];
    end
    for (int i = 0; i < 3; i++) begin
      amag = pc.vec[i][31] ? (~pc.vec[i] + 32'd1) : pc.vec[i];
      dmag = pc.den[i][31] ? (~pc.den[i] + 32'd1) : pc.den[i];
      post_nxt.aneg[i] = pc.vec[i][31];
      post_nxt.dzl[i]  = (pc.cmd inside {CMD_DIVV, CMD_DIVS}) && (pc.den[i] == '0);
      if (pc.cmd == CMD_NORM) begin
        post_nxt.qneg[i] = pc.vec[i][31];
        dsr0_nxt[i]      = len;
      end else begin
        post_nxt.qneg[i] = pc.vec[i][31] ^ pc.den[i][31];
        dsr0_nxt[i]      = dmag;
      end
      qd0_nxt[i] = {amag, {FRAC_BITS{1'b0}}};
    end
  end

  // ---------------------------------------------------------------- restoring dividers
  always_comb begin
    logic [32:0] rs;
    logic        ge;
    for (int i = 0; i < 3; i++) begin
      rem_nxt[0][i] = '0;
      qd_nxt[0][i]  = qd0_nxt[i];
      dsr_nxt[0][i] = dsr0_nxt[i];
    end
    for (int j = 0; j < DW; j++) begin
      for (int i = 0; i < 3; i++) begin
        rs = {rem_r[j][i][31:0], qd_r[j][i][DW-1]};
        ge = (rs >= {1'b0, dsr_r[j][i]});
        rem_nxt[j+1][i] = ge ? (rs - {1'b0, dsr_r[j][i]}) : rs;
        qd_nxt[j+1][i]  = {qd_r[j][i][DW-2:0], ge};
        dsr_nxt[j+1][i] = dsr_r[j][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      post_r[0] <= post_nxt;
      for (int j = 1; j <= DW; j++) begin
        post_r[j] <= post_r[j-1];
      end
      for (int j = 0; j <= DW; j++) begin
        for (int i = 0; i < 3; i++) begin
          rem_r[j][i] <= rem_nxt[j][i];
          qd_r[j][i]  <= qd_nxt[j][i];
          dsr_r[j][i] <= dsr_nxt[j][i];
        end
      end
    end
  end

  // ---------------------------------------------------------------- result selection
  always_comb begin
    post_t         pp;
    logic [DW-1:0] q;
    logic          dsat;
    logic [31:0]   dres;
    word_t [2:0]   vec;
    logic          sat;
    logic          dz;
    pp  = post_r[DW];
    vec = pp.vec;
    sat = pp.sat;
    dz  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = qd_r[DW][i];
      if (pp.qneg[i]) begin
        dsat = (|q[DW-1:32]) || (q[31] && (|q[30:0]));
        dres = dsat ? W_MIN : (~q[31:0] + 32'd1);
      end else begin
        dsat = |q[DW-1:31];
        dres = dsat ? W_MAX : q[31:0];
      end
      case (pp.cmd)
        CMD_DIVV, CMD_DIVS: begin
          if (pp.dzl[i]) begin
            vec[i] = pp.aneg[i] ? W_MIN : W_MAX;
            dz     = 1'b1;
          end else begin
            vec[i] = dres;
            sat    = sat | dsat;
          end
        end
        CMD_NORM: begin
          if (!pp.zl) begin
            vec[i] = dres;
            sat    = sat | dsat;
          end
        end
        default: begin
          vec[i] = pp.vec[i];
        end
      endcase
    end
    out_data_nxt = {pp.sc, vec[2], vec[1], vec[0]};
    out_user_nxt = {pp.zl, dz, sat};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

endmodule
